// ===== hw/rtl/farm_pkg.sv =====
// Shared types and constants for the frame allocator with reverse map.
// Used by the channel interfaces, the controller, the datapath and the top level.
package farm_pkg;

  localparam int FRAME_COUNT = 128;
  localparam int FRAME_BYTES = 64;
  localparam int FIRST_FREE  = 3;

  localparam int ACTION_W = 2;
  localparam int PAGE_W   = 16;
  localparam int FRAME_W  = 7;
  localparam int BASE_W   = 13;

  localparam int IDX_W       = $clog2(FRAME_COUNT);
  localparam int OFFSET_W    = $clog2(FRAME_BYTES);
  localparam int GROUP_SIZE  = 8;
  localparam int BIT_W       = $clog2(GROUP_SIZE);
  localparam int GROUP_COUNT = FRAME_COUNT / GROUP_SIZE;
  localparam int GRP_W       = $clog2(GROUP_COUNT);

  // frames below FIRST_FREE are reserved at reset and never handed out
  localparam logic [FRAME_COUNT-1:0] RESERVED_MASK = FRAME_COUNT'((1 << FIRST_FREE) - 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_SPARE = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    logic ready;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } sts_t;

endpackage

// ===== hw/rtl/farm_if.sv =====
// Request and result channel interfaces for the frame allocator.
// Widths come from farm_pkg.
interface farm_req_if;
  logic                          valid;
  logic                          ready;
  logic [farm_pkg::ACTION_W-1:0] action;
  logic [farm_pkg::PAGE_W-1:0]   owner_page;
  logic                          swap_ok;
  logic [farm_pkg::FRAME_W-1:0]  frame_in;

  modport source (output valid, action, owner_page, swap_ok, frame_in, input ready);
  modport sink   (input valid, action, owner_page, swap_ok, frame_in, output ready);
endinterface

interface farm_res_if;
  logic                         valid;
  logic                         ready;
  logic [farm_pkg::FRAME_W-1:0] frame_out;
  logic                         full_res;
  logic [farm_pkg::BASE_W-1:0]  base_address;
  logic [farm_pkg::PAGE_W-1:0]  owner_out;
  logic                         swappable_out;
  logic                         allocated_out;

  modport source (output valid, frame_out, full_res, base_address, owner_out,
                  swappable_out, allocated_out, input ready);
  modport sink   (input valid, frame_out, full_res, base_address, owner_out,
                  swappable_out, allocated_out, output ready);
endinterface

// ===== hw/rtl/frame_allocator_reverse_map.sv =====
// Top level of the frame allocator with reverse map.
// Instantiates farm_ctrl and farm_datapath; uses farm_pkg and farm_if.
//
// A request is handled in the accept cycle, which registers one free flag per
// group of eight frames and reads the owner table memory at frame_in, and then in
// the search state, which picks the lowest free group and bit, updates the allocated,
// swappable and owner state and loads the result register. A new request is
// taken in the cycle after the result is loaded, so a new request is not taken
// before the last one is through; a stalled result holds the search state until
// the result register frees. No clearing pass after reset.
module frame_allocator_reverse_map (
  input  logic clk,
  input  logic rst,
  farm_req_if.sink   req,
  farm_res_if.source res
);

  farm_pkg::cmd_t cmd;
  farm_pkg::sts_t sts;

  farm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  farm_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .res (res)
  );

endmodule

// ===== hw/rtl/farm_ctrl.sv =====
// Controller for the frame allocator: takes a request, then commits it once
// the result register is free. Uses farm_pkg types.
module farm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  farm_pkg::sts_t   sts,
  output farm_pkg::cmd_t   cmd
);

  farm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= farm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      farm_pkg::ST_IDLE: begin
        if (req_valid) state_next = farm_pkg::ST_SEARCH;
      end
      farm_pkg::ST_SEARCH: begin
        if (sts.slot_free) state_next = farm_pkg::ST_IDLE;
      end
      default: state_next = farm_pkg::ST_IDLE;
    endcase
  end

  // no request is taken while reset is held
  always_comb begin
    cmd = '0;
    case (state)
      farm_pkg::ST_IDLE:   cmd.ready  = !rst;
      farm_pkg::ST_SEARCH: cmd.commit = sts.slot_free;
      default:             cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/farm_datapath.sv =====
// Datapath of the frame allocator: allocated and written bits, owner table
// memory, two-level free-frame search and result register. Uses farm_pkg.
module farm_datapath (
  input  logic              clk,
  input  logic              rst,
  input  farm_pkg::cmd_t    cmd,
  output farm_pkg::sts_t    sts,
  farm_req_if.sink          req,
  farm_res_if.source        res
);

  localparam int ENTRY_W = farm_pkg::PAGE_W + 1;

  logic [farm_pkg::FRAME_COUNT-1:0] used;
  logic [farm_pkg::FRAME_COUNT-1:0] written;
  logic [ENTRY_W-1:0]               owner_mem [farm_pkg::FRAME_COUNT];

  logic [farm_pkg::ACTION_W-1:0]    r_action;
  logic [farm_pkg::PAGE_W-1:0]      r_page;
  logic                             r_swap;
  logic [farm_pkg::FRAME_W-1:0]     r_frame;
  logic [ENTRY_W-1:0]               rd_data;
  logic                             rd_written;
  logic [farm_pkg::GROUP_COUNT-1:0] group_any;
  logic [farm_pkg::GROUP_COUNT-1:0] group_any_next;

  logic                             out_valid;
  logic                             accepted;
  logic [farm_pkg::FRAME_COUNT-1:0] free_vec;
  logic [farm_pkg::GRP_W-1:0]       grp_sel;
  logic [farm_pkg::GROUP_SIZE-1:0]  grp_bits;
  logic [farm_pkg::BIT_W-1:0]       bit_sel;
  logic                             found;
  logic [farm_pkg::IDX_W-1:0]       alloc_idx;
  logic [farm_pkg::IDX_W-1:0]       req_idx;
  logic [farm_pkg::IDX_W-1:0]       r_idx;
  logic                             r_in_range;

  logic [farm_pkg::FRAME_W-1:0]     frame_res;
  logic                             full_bit;
  logic [farm_pkg::PAGE_W-1:0]      owner_res;
  logic                             swap_res;
  logic                             alloc_res;

  assign req.ready     = cmd.ready;
  assign accepted      = req.valid && cmd.ready;
  assign sts.slot_free = !out_valid || res.ready;

  assign req_idx    = farm_pkg::IDX_W'(req.frame_in);
  assign r_idx      = farm_pkg::IDX_W'(r_frame);
  assign r_in_range = 32'(r_frame) < farm_pkg::FRAME_COUNT;

  assign free_vec = ~used & ~farm_pkg::RESERVED_MASK;

  always_comb begin
    for (int k = 0; k < farm_pkg::GROUP_COUNT; k++) begin
      group_any_next[k] = |free_vec[k*farm_pkg::GROUP_SIZE +: farm_pkg::GROUP_SIZE];
    end
  end

  // second level of the search: lowest group with a free frame, then lowest bit
  always_comb begin
    grp_sel = '0;
    for (int k = farm_pkg::GROUP_COUNT - 1; k >= 0; k--) begin
      if (group_any[k]) grp_sel = farm_pkg::GRP_W'(k);
    end
    grp_bits = free_vec[{grp_sel, farm_pkg::BIT_W'(0)} +: farm_pkg::GROUP_SIZE];
    bit_sel  = '0;
    for (int b = farm_pkg::GROUP_SIZE - 1; b >= 0; b--) begin
      if (grp_bits[b]) bit_sel = farm_pkg::BIT_W'(b);
    end
  end

  assign found     = |group_any;
  assign alloc_idx = {grp_sel, bit_sel};

  always_comb begin
    frame_res = r_frame;
    full_bit  = 1'b0;
    owner_res = '0;
    swap_res  = 1'b0;
    alloc_res = 1'b0;
    if (r_action == farm_pkg::ACT_ALLOC) begin
      if (found) begin
        frame_res = farm_pkg::FRAME_W'(alloc_idx);
        owner_res = r_page;
        swap_res  = r_swap;
        alloc_res = 1'b1;
      end else begin
        frame_res = '0;
        full_bit  = 1'b1;
      end
    end else if (r_in_range) begin
      // unwritten entries read as the reset value
      owner_res = rd_written ? rd_data[farm_pkg::PAGE_W-1:0] : '0;
      swap_res  = rd_written & rd_data[farm_pkg::PAGE_W];
      alloc_res = (r_action == farm_pkg::ACT_FREE) ? 1'b0 : used[r_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= farm_pkg::RESERVED_MASK;
      written   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (r_action == farm_pkg::ACT_ALLOC) begin
          if (found) begin
            used[alloc_idx]    <= 1'b1;
            written[alloc_idx] <= 1'b1;
          end
        end else if (r_action == farm_pkg::ACT_FREE && r_in_range) begin
          used[r_idx] <= 1'b0;
        end
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && r_action == farm_pkg::ACT_ALLOC && found) begin
      owner_mem[alloc_idx] <= {r_swap, r_page};
    end
    if (accepted) begin
      rd_data <= owner_mem[req_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accepted) begin
      r_action   <= req.action;
      r_page     <= req.owner_page;
      r_swap     <= req.swap_ok;
      r_frame    <= req.frame_in;
      rd_written <= written[req_idx];
      group_any  <= group_any_next;
    end
    if (cmd.commit) begin
      res.frame_out     <= frame_res;
      res.full_res      <= full_bit;
      res.base_address  <= farm_pkg::BASE_W'(farm_pkg::BASE_W'(frame_res) << farm_pkg::OFFSET_W);
      res.owner_out     <= owner_res;
      res.swappable_out <= swap_res;
      res.allocated_out <= alloc_res;
    end
  end

  assign res.valid = out_valid;

endmodule

// ===== tb/tb_frame_allocator_reverse_map.sv =====
// Self-checking testbench for frame_allocator_reverse_map: request and result channels
// are driven and sampled at the clock edge, and every result is compared with a predictor.
// Depends on farm_pkg, farm_if and the allocator RTL.
module tb_frame_allocator_reverse_map;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [farm_pkg::FRAME_W-1:0] frame;
    logic                         full;
    logic [farm_pkg::BASE_W-1:0]  base;
    logic [farm_pkg::PAGE_W-1:0]  owner;
    logic                         swappable;
    logic                         allocated;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst;

  farm_req_if req_ch ();
  farm_res_if res_ch ();

  frame_allocator_reverse_map dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always #5 clk = ~clk;

  // predictor state, one entry per frame
  logic                        frame_used      [farm_pkg::FRAME_COUNT];
  logic                        frame_swappable [farm_pkg::FRAME_COUNT];
  logic [farm_pkg::PAGE_W-1:0] frame_owner     [farm_pkg::FRAME_COUNT];

  frame_result_t pending_frame_results[$];
  int            error_count     = 0;
  bit            no_idle         = 1'b0;
  int            hold_off_cycles = 0;

  function automatic frame_result_t describe_frame(int f, bit in_range);
    frame_result_t r;
    r      = '0;
    r.frame = farm_pkg::FRAME_W'(f);
    r.base  = farm_pkg::BASE_W'(f * farm_pkg::FRAME_BYTES);
    if (in_range) begin
      r.owner     = frame_owner[f];
      r.swappable = frame_swappable[f];
      r.allocated = frame_used[f];
    end
    return r;
  endfunction

  function automatic frame_result_t predict_frame_result(
      farm_pkg::action_t act,
      logic [farm_pkg::PAGE_W-1:0] page,
      logic sw,
      logic [farm_pkg::FRAME_W-1:0] frm);
    frame_result_t r;
    int            f;
    bit            found;
    if (act == farm_pkg::ACT_ALLOC) begin
      r      = '0;
      r.full = 1'b1;
      found  = 1'b0;
      for (f = farm_pkg::FIRST_FREE; f < farm_pkg::FRAME_COUNT && !found; f++) begin
        if (!frame_used[f]) begin
          frame_used[f]      = 1'b1;
          frame_swappable[f] = sw;
          frame_owner[f]     = page;
          r                  = describe_frame(f, 1'b1);
          found              = 1'b1;
        end
      end
      return r;
    end
    // free, query and the spare action all report frame_in
    if (act == farm_pkg::ACT_FREE && int'(frm) < farm_pkg::FRAME_COUNT)
      frame_used[frm] = 1'b0;
    return describe_frame(int'(frm), int'(frm) < farm_pkg::FRAME_COUNT);
  endfunction

  function automatic int count_free_frames();
    int f;
    int n;
    n = 0;
    for (f = farm_pkg::FIRST_FREE; f < farm_pkg::FRAME_COUNT; f++) if (!frame_used[f]) n++;
    return n;
  endfunction

  // mostly an allocated frame, so frees hit live entries; otherwise the random one
  function automatic logic [farm_pkg::FRAME_W-1:0] pick_allocated_frame(
      logic [farm_pkg::FRAME_W-1:0] fallback);
    int busy[$];
    int f;
    for (f = 0; f < farm_pkg::FRAME_COUNT; f++) if (frame_used[f]) busy.push_back(f);
    if (busy.size() == 0 || $urandom_range(0, 99) < 15) return fallback;
    return farm_pkg::FRAME_W'(busy[$urandom_range(0, busy.size() - 1)]);
  endfunction

  task automatic send_request(input farm_pkg::action_t act,
                              input logic [farm_pkg::PAGE_W-1:0] page,
                              input logic sw,
                              input logic [farm_pkg::FRAME_W-1:0] frm);
    if (!no_idle && $urandom_range(0, 99) < 13) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.owner_page <= page;
    req_ch.swap_ok    <= sw;
    req_ch.frame_in   <= frm;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_frame_results.push_back(predict_frame_result(act, page, sw, frm));
  endtask

  task automatic send_random_request(input farm_pkg::action_t act);
    logic [farm_pkg::FRAME_W-1:0] frm;
    frm = farm_pkg::FRAME_W'($urandom_range(0, farm_pkg::FRAME_COUNT - 1));
    if (act == farm_pkg::ACT_FREE) frm = pick_allocated_frame(frm);
    send_request(act, farm_pkg::PAGE_W'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)), frm);
  endtask

  task automatic wait_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_frame_results.size() != 0);
  endtask

  task automatic test_directed();
    send_request(farm_pkg::ACT_QUERY, 16'h0000, 1'b0, 7'd0);
    send_request(farm_pkg::ACT_QUERY, 16'h0000, 1'b0, 7'd2);
    send_request(farm_pkg::ACT_QUERY, 16'hFFFF, 1'b1, 7'd127);
    send_request(farm_pkg::ACT_SPARE, 16'h0000, 1'b0, 7'd1);
    send_request(farm_pkg::ACT_ALLOC, 16'hFFFF, 1'b1, 7'd0);
    send_request(farm_pkg::ACT_ALLOC, 16'h0000, 1'b0, 7'd127);
    send_request(farm_pkg::ACT_ALLOC, 16'hA5A5, 1'b1, 7'd0);
    send_request(farm_pkg::ACT_QUERY, 16'h0000, 1'b0, 7'd3);
    send_request(farm_pkg::ACT_SPARE, 16'h0000, 1'b0, 7'd5);
    send_request(farm_pkg::ACT_FREE,  16'h0000, 1'b0, 7'd4);
    send_request(farm_pkg::ACT_QUERY, 16'h0000, 1'b0, 7'd4);
    // the freed slot is the lowest free one again
    send_request(farm_pkg::ACT_ALLOC, 16'h5A5A, 1'b0, 7'd0);
    // freeing a reserved frame clears its bit but alloc still starts at 3
    send_request(farm_pkg::ACT_FREE,  16'h0000, 1'b0, 7'd0);
    send_request(farm_pkg::ACT_QUERY, 16'h0000, 1'b0, 7'd0);
    send_request(farm_pkg::ACT_ALLOC, 16'h1234, 1'b1, 7'd0);
    send_request(farm_pkg::ACT_FREE,  16'h0000, 1'b0, 7'd127);
    send_request(farm_pkg::ACT_QUERY, 16'h0000, 1'b0, 7'd127);
    send_request(farm_pkg::ACT_FREE,  16'h0000, 1'b0, 7'd3);
    send_request(farm_pkg::ACT_FREE,  16'h0000, 1'b0, 7'd3);
    send_request(farm_pkg::ACT_QUERY, 16'h0000, 1'b0, 7'd3);
    send_request(farm_pkg::ACT_ALLOC, 16'h8001, 1'b1, 7'd0);
    send_request(farm_pkg::ACT_SPARE, 16'hFFFF, 1'b1, 7'd127);
  endtask

  // back-to-back allocates into a full table, no idling on either side
  task automatic test_fill_to_full();
    int n;
    int k;
    no_idle = 1'b1;
    n = count_free_frames() + 4;
    for (k = 0; k < n; k++) send_random_request(farm_pkg::ACT_ALLOC);
    send_random_request(farm_pkg::ACT_QUERY);
    send_random_request(farm_pkg::ACT_FREE);
    send_random_request(farm_pkg::ACT_ALLOC);
    send_random_request(farm_pkg::ACT_ALLOC);
    no_idle = 1'b0;
  endtask

  task automatic test_result_backpressure();
    int k;
    hold_off_cycles = 80;
    for (k = 0; k < 12; k++)
      send_random_request(k % 3 == 0 ? farm_pkg::ACT_FREE : farm_pkg::ACT_ALLOC);
  endtask

  task automatic test_sender_pause();
    int k;
    for (k = 0; k < 10; k++)
      send_random_request(k % 2 == 0 ? farm_pkg::ACT_ALLOC : farm_pkg::ACT_QUERY);
    wait_until_drained();
    for (k = 0; k < 10; k++)
      send_random_request(k % 2 == 0 ? farm_pkg::ACT_FREE : farm_pkg::ACT_ALLOC);
  endtask

  // alternating phases push the table towards full, then towards empty
  task automatic test_random_traffic(input int n_requests);
    int                k;
    int                pick;
    int                alloc_w;
    int                free_w;
    farm_pkg::action_t act;
    for (k = 0; k < n_requests; k++) begin
      if ((k / 70) % 2 == 0) begin
        alloc_w = 60;
        free_w  = 15;
      end else begin
        alloc_w = 15;
        free_w  = 50;
      end
      pick = $urandom_range(0, 99);
      if (pick < alloc_w)               act = farm_pkg::ACT_ALLOC;
      else if (pick < alloc_w + free_w) act = farm_pkg::ACT_FREE;
      else if (pick < 96)               act = farm_pkg::ACT_QUERY;
      else                              act = farm_pkg::ACT_SPARE;
      send_random_request(act);
    end
  endtask

  function automatic void compare_field(string name, logic [31:0] expected,
                                        logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      error_count++;
    end
  endfunction

  task automatic check_frame_result();
    frame_result_t exp;
    if (pending_frame_results.size() == 0) begin
      $error("result with no request outstanding: frame_out %0d", res_ch.frame_out);
      error_count++;
      return;
    end
    exp = pending_frame_results.pop_front();
    compare_field("frame_out",     32'(exp.frame),     32'(res_ch.frame_out));
    compare_field("full_res",      32'(exp.full),      32'(res_ch.full_res));
    compare_field("base_address",  32'(exp.base),      32'(res_ch.base_address));
    compare_field("owner_out",     32'(exp.owner),     32'(res_ch.owner_out));
    compare_field("swappable_out", 32'(exp.swappable), 32'(res_ch.swappable_out));
    compare_field("allocated_out", 32'(exp.allocated), 32'(res_ch.allocated_out));
  endtask

  initial begin : result_side
    int stall_left;
    stall_left   = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        check_frame_result();
      if (hold_off_cycles > 0) begin
        stall_left      = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= no_idle || $urandom_range(0, 99) >= 13;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int f;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.action     <= farm_pkg::ACT_QUERY;
    req_ch.owner_page <= '0;
    req_ch.swap_ok    <= 1'b0;
    req_ch.frame_in   <= '0;
    for (f = 0; f < farm_pkg::FRAME_COUNT; f++) begin
      frame_used[f]      = (f < farm_pkg::FIRST_FREE);
      frame_swappable[f] = 1'b0;
      frame_owner[f]     = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill_to_full();
    test_result_backpressure();
    test_sender_pause();
    test_random_traffic(960);

    wait_until_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
